[sv/vibe_pkg.sv]
package vibe_pkg;

  localparam int Samples = 20;
  localparam int ImgWidth = 320;
  localparam int ImgHeight = 240;
  localparam int NPix = ImgWidth * ImgHeight;
  localparam int SmpAddrW = $clog2(NPix * Samples);
  localparam int PixAddrW = $clog2(NPix);
  localparam int SlotW = 5;
  localparam int RowW = 8;
  localparam int ColW = 9;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_DETECT = 1'b1;

  localparam logic [1:0] REG_RGB_MODE = 2'd0;
  localparam logic [1:0] REG_MAX_DIST = 2'd1;
  localparam logic [1:0] REG_MIN_MATCH = 2'd2;
  localparam logic [1:0] REG_UPD_SHIFT = 2'd3;

  typedef struct packed {
    logic             in_frame;
    logic             func;
    logic [PixAddrW-1:0] pix;
    logic [PixAddrW-1:0] npix;
    logic [23:0]      px;
    logic [SlotW-1:0] own_slot;
    logic             own_ok;
    logic             spread_ok;
    logic [SlotW-1:0] spread_slot;
    logic             hit_update;
    logic             hit_spread;
  } vibe_job_t;

  typedef struct packed {
    logic       rgb_mode;
    logic [8:0] max_distance;
    logic [4:0] min_matches;
    logic [3:0] update_shift;
  } vibe_cfg_t;

  function automatic logic roll_hit(input logic [7:0] roll, input logic [3:0] sh);
    logic [3:0] s;
    logic [7:0] mask;
    s = (sh > 4'd8) ? 4'd8 : sh;
    mask = 8'((9'd1 << s) - 9'd1);
    return (roll & mask) == 8'd0;
  endfunction

endpackage

[sv/vibe_ram.sv]
module vibe_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

[sv/vibe_front.sv]
module vibe_front import vibe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  vibe_cfg_t  cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       func,
  input  logic [7:0] pix_row,
  input  logic [8:0] pix_col,
  input  logic [7:0] chan0,
  input  logic [7:0] chan1,
  input  logic [7:0] chan2,
  input  logic [4:0] own_slot,
  input  logic [7:0] roll_update,
  input  logic [7:0] roll_spread,
  input  logic [4:0] spread_slot,
  input  logic [1:0] row_step,
  input  logic [1:0] col_step,
  output logic       q_valid,
  input  logic       q_ready,
  output vibe_job_t  q_job
);

  // two-entry queue toward the back part
  vibe_job_t  q_mem [2];
  logic [1:0] q_cnt;
  logic       wr_ptr, rd_ptr;
  vibe_job_t  job;
  logic [RowW-1:0] nr;
  logic [ColW-1:0] nc;
  logic push, pop;

  always_comb begin
    nr = pix_row;
    nc = pix_col;
    if (row_step == 2'd0 && pix_row != '0) nr = pix_row - 8'd1;
    if (row_step == 2'd2 && 32'(pix_row) + 1 < ImgHeight) nr = pix_row + 8'd1;
    if (col_step == 2'd0 && pix_col != '0) nc = pix_col - 9'd1;
    if (col_step == 2'd2 && 32'(pix_col) + 1 < ImgWidth) nc = pix_col + 9'd1;
    job.in_frame = (32'(pix_row) < ImgHeight) && (32'(pix_col) < ImgWidth);
    job.func = func;
    job.pix = PixAddrW'(32'(pix_row) * ImgWidth + 32'(pix_col));
    job.npix = PixAddrW'(32'(nr) * ImgWidth + 32'(nc));
    job.px = cfg.rgb_mode ? {chan2, chan1, chan0} : {16'd0, chan0};
    job.own_slot = own_slot;
    job.own_ok = 32'(own_slot) < Samples;
    job.spread_slot = spread_slot;
    job.spread_ok = 32'(spread_slot) < Samples;
    job.hit_update = roll_hit(roll_update, cfg.update_shift);
    job.hit_spread = roll_hit(roll_spread, cfg.update_shift);
  end

  assign in_ready = (q_cnt != 2'd2);
  assign push = in_valid && in_ready;
  assign pop = q_valid && q_ready;
  assign q_valid = (q_cnt != 2'd0);
  assign q_job = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) q_mem[wr_ptr] <= job;
    if (rst) begin
      q_cnt <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      q_cnt <= q_cnt + 2'(push) - 2'(pop);
    end
  end

endmodule

[sv/vibe_back.sv]
module vibe_back import vibe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  vibe_cfg_t  cfg,
  input  logic       q_valid,
  output logic       q_ready,
  input  vibe_job_t  q_job,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       foreground,
  output logic [7:0] est_bg0,
  output logic [7:0] est_bg1,
  output logic [7:0] est_bg2
);

  localparam int CntW = $clog2(Samples + 1);
  localparam int IdxW = $clog2(Samples + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_WRITE = 3'd3;
  localparam logic [2:0] ST_EST   = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0] state;
  vibe_job_t job;
  logic [IdxW-1:0] idx;
  logic [CntW-1:0] count;
  logic fg;
  logic est_new;

  logic smp_we;
  logic [SmpAddrW-1:0] smp_waddr, smp_raddr;
  logic [23:0] smp_wdata, smp_rdata;
  logic est_we;
  logic [PixAddrW-1:0] est_waddr;
  logic [23:0] est_wdata, est_rdata;

  // distance check, registered product terms before the compare
  logic signed [8:0] d0, d1, d2;
  logic [16:0] sq0, sq1, sq2;
  logic [9:0] lim;
  logic [19:0] lim_sq;
  logic [18:0] ssum;
  logic close;
  logic scan_vld, d_vld, sq_vld;
  logic [7:0] ad0;

  vibe_ram #(.Width(24), .Depth(NPix * Samples)) u_smp (
    .clk(clk), .we(smp_we), .waddr(smp_waddr), .wdata(smp_wdata),
    .raddr(smp_raddr), .rdata(smp_rdata)
  );

  vibe_ram #(.Width(24), .Depth(NPix)) u_est (
    .clk(clk), .we(est_we), .waddr(est_waddr), .wdata(est_wdata),
    .raddr(job.pix), .rdata(est_rdata)
  );

  assign smp_raddr = SmpAddrW'(32'(job.pix) * Samples + 32'(idx));
  assign q_ready = (state == ST_IDLE);
  assign lim = 10'(cfg.max_distance) + 10'd1;

  always_ff @(posedge clk) begin
    d0 <= $signed({1'b0, job.px[7:0]}) - $signed({1'b0, smp_rdata[7:0]});
    d1 <= $signed({1'b0, job.px[15:8]}) - $signed({1'b0, smp_rdata[15:8]});
    d2 <= $signed({1'b0, job.px[23:16]}) - $signed({1'b0, smp_rdata[23:16]});
    sq0 <= 17'(d0 * d0);
    sq1 <= 17'(d1 * d1);
    sq2 <= 17'(d2 * d2);
    ad0 <= d0[8] ? 8'(-d0) : d0[7:0];
    lim_sq <= lim * lim;
  end

  assign ssum = 19'(sq0) + 19'(sq1) + 19'(sq2);
  assign close = cfg.rgb_mode ? (20'(ssum) < lim_sq) : (9'(ad0) <= cfg.max_distance);

  always_comb begin
    smp_we = 1'b0;
    smp_waddr = SmpAddrW'(32'(job.pix) * Samples + 32'(job.own_slot));
    smp_wdata = job.px;
    est_we = 1'b0;
    est_waddr = job.pix;
    est_wdata = job.px;
    if (state == ST_WRITE) begin
      if (job.func == FUNC_LOAD) begin
        smp_we = job.own_ok;
        est_we = job.own_ok && job.own_slot == '0;
      end else if (!fg) begin
        smp_we = job.hit_update && job.own_ok;
        est_we = job.hit_update;
      end
    end else if (state == ST_EST) begin
      smp_waddr = SmpAddrW'(32'(job.npix) * Samples + 32'(job.spread_slot));
      smp_we = job.func == FUNC_DETECT && !fg && job.hit_spread && job.spread_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      scan_vld <= 1'b0;
      d_vld <= 1'b0;
      sq_vld <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: if (q_valid) begin
          job <= q_job;
          idx <= '0;
          count <= '0;
          scan_vld <= 1'b0;
          d_vld <= 1'b0;
          sq_vld <= 1'b0;
          if (!q_job.in_frame) begin
            fg <= 1'b0;
            foreground <= 1'b0;
            {est_bg2, est_bg1, est_bg0} <= '0;
            out_valid <= 1'b1;
            state <= ST_OUT;
          end else if (q_job.func == FUNC_LOAD) begin
            fg <= 1'b0;
            state <= ST_WRITE;
          end else begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          // one sample a cycle, piped through the memory read, difference and square registers to the compare
          idx <= idx + IdxW'(1);
          scan_vld <= 1'b1;
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          d_vld <= scan_vld;
          sq_vld <= d_vld;
          if (sq_vld) count <= count + CntW'(close);
          if (32'(idx) < Samples) begin
            idx <= idx + IdxW'(1);
            scan_vld <= 1'b1;
          end else if (scan_vld || d_vld || sq_vld) begin
            scan_vld <= 1'b0;
          end else begin
            fg <= 32'(count) < 32'(cfg.min_matches);
            state <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          // the estimate read port still shows the old word after a write
          est_new <= est_we;
          state <= ST_EST;
        end
        ST_EST: begin
          foreground <= fg;
          {est_bg2, est_bg1, est_bg0} <= est_new ? job.px : est_rdata;
          out_valid <= 1'b1;
          state <= ST_OUT;
        end
        ST_OUT: if (out_ready) begin
          out_valid <= 1'b0;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[sv/vibe_pixel_classify_update_unit.sv]
// vibe background subtraction, one pixel word per item
// channels: in (in_valid/in_ready) carries load or detect words with pixel
//   address, color and random draws; out (out_valid/out_ready) returns one
//   word per item: foreground flag and the pixel's background estimate;
//   cfg (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the four registers
// a front stage accepts words, computes addresses, neighbour clamp and
//   update draws, and pushes them into a two-entry queue
// the back stage reads one stored sample a cycle from the sample memory
//   through the memory read, difference and square registers to the compare,
//   then writes own sample, estimate and neighbour sample
// the back stage takes the next word from the queue only after the result
//   of the last word has been taken by the receiver
// reset clears control and restores register defaults; memories keep
//   their contents, every pixel must be loaded before use
// a stalled receiver holds the result; the front keeps filling the queue
//   until both entries are taken, then in_ready drops
module vibe_pixel_classify_update_unit import vibe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       func,
  input  logic [7:0] pix_row,
  input  logic [8:0] pix_col,
  input  logic [7:0] chan0,
  input  logic [7:0] chan1,
  input  logic [7:0] chan2,
  input  logic [4:0] own_slot,
  input  logic [7:0] roll_update,
  input  logic [7:0] roll_spread,
  input  logic [4:0] spread_slot,
  input  logic [1:0] row_step,
  input  logic [1:0] col_step,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       foreground,
  output logic [7:0] est_bg0,
  output logic [7:0] est_bg1,
  output logic [7:0] est_bg2
);

  vibe_cfg_t cfg;
  logic q_valid, q_ready;
  vibe_job_t q_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rgb_mode <= 1'b1;
      cfg.max_distance <= 9'd20;
      cfg.min_matches <= 5'd2;
      cfg.update_shift <= 4'd4;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_RGB_MODE: cfg.rgb_mode <= cfg_data[0];
        REG_MAX_DIST: cfg.max_distance <= cfg_data;
        REG_MIN_MATCH: cfg.min_matches <= cfg_data[4:0];
        REG_UPD_SHIFT: cfg.update_shift <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  vibe_front u_front (
    .clk(clk), .rst(rst), .cfg(cfg), .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .pix_row(pix_row), .pix_col(pix_col), .chan0(chan0),
    .chan1(chan1), .chan2(chan2), .own_slot(own_slot), .roll_update(roll_update),
    .roll_spread(roll_spread), .spread_slot(spread_slot), .row_step(row_step),
    .col_step(col_step), .q_valid(q_valid), .q_ready(q_ready), .q_job(q_job)
  );

  vibe_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_valid(q_valid), .q_ready(q_ready),
    .q_job(q_job), .out_valid(out_valid), .out_ready(out_ready),
    .foreground(foreground), .est_bg0(est_bg0), .est_bg1(est_bg1),
    .est_bg2(est_bg2)
  );

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(foreground) && $stable(est_bg0))
    else $error("result changed while stalled");

  // the front is never full while its queue offers no word
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> q_valid)
    else $error("front full with empty queue output");

  // the back part takes no word while a result waits
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !q_ready)
    else $error("queue read while a result waits");

endmodule

[bench/tb_vibe_pixel_classify_update_unit.sv]
`timescale 1ns / 1ps

module tb_vibe_pixel_classify_update_unit import vibe_pkg::*; ();

  typedef struct {
    logic       func;
    logic [7:0] row;
    logic [8:0] col;
    logic [7:0] c0, c1, c2;
    logic [4:0] own;
    logic [7:0] roll_upd;
    logic [7:0] roll_spr;
    logic [4:0] spr_slot;
    logic [1:0] rstep, cstep;
  } pixel_word_t;

  typedef struct {
    logic       fg;
    logic [7:0] e0, e1, e2;
  } verdict_t;

  localparam int PoolN = 16;
  localparam int HoldCycles = 400;
  localparam int Drain = 60;
  localparam int CycleLimit = 1000000;

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [8:0] cfg_data;
  logic in_valid, in_ready;
  logic func;
  logic [7:0] pix_row;
  logic [8:0] pix_col;
  logic [7:0] chan0, chan1, chan2;
  logic [4:0] own_slot;
  logic [7:0] roll_update, roll_spread;
  logic [4:0] spread_slot;
  logic [1:0] row_step, col_step;
  logic out_valid, out_ready;
  logic foreground;
  logic [7:0] est_bg0, est_bg1, est_bg2;

  vibe_pixel_classify_update_unit dut (.*);

  // model copy of the block
  logic       m_rgb;
  logic [8:0] m_maxd;
  logic [4:0] m_minm;
  logic [3:0] m_shift;
  logic [23:0] samples_mem [int];
  logic [23:0] estimate_mem [int];

  pixel_word_t pending_words[$];
  verdict_t    expected_verdicts[$];
  int errors = 0;
  int words_sent = 0;
  int verdicts_seen = 0;
  int fg_seen = 0;
  bit quiet = 0;
  bit hold_req = 0;
  bit hold_done = 0;
  int gap_cnt = 0;
  int stall_cnt = 0;
  int hold_cnt = 0;
  int cycles = 0;

  // generator view of the pixel pool
  int pool_row [PoolN];
  int pool_col [PoolN];
  logic [23:0] pool_color [PoolN];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [23:0] pack_px(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    return m_rgb ? {c, b, a} : {16'd0, a};
  endfunction

  function automatic bit near(logic [23:0] px, logic [23:0] s);
    int d0, d1, d2, lim;
    d0 = int'(px[7:0]) - int'(s[7:0]);
    d1 = int'(px[15:8]) - int'(s[15:8]);
    d2 = int'(px[23:16]) - int'(s[23:16]);
    lim = int'(m_maxd) + 1;
    if (!m_rgb) return (d0 < 0 ? -d0 : d0) <= int'(m_maxd);
    return d0 * d0 + d1 * d1 + d2 * d2 < lim * lim;
  endfunction

  function automatic bit draw_hits(logic [7:0] roll);
    int sh;
    sh = m_shift > 8 ? 8 : int'(m_shift);
    return (int'(roll) & ((1 << sh) - 1)) == 0;
  endfunction

  function automatic verdict_t classify_pixel(pixel_word_t w);
    verdict_t v;
    int pix, nr, nc, cnt;
    logic [23:0] px, e;
    v = '{fg: 1'b0, e0: 8'd0, e1: 8'd0, e2: 8'd0};
    if (w.row >= ImgHeight || w.col >= ImgWidth) return v;
    pix = int'(w.row) * ImgWidth + int'(w.col);
    px = pack_px(w.c0, w.c1, w.c2);
    if (w.func == FUNC_LOAD) begin
      if (w.own < Samples) begin
        samples_mem[pix * 32 + int'(w.own)] = px;
        if (w.own == 0) estimate_mem[pix] = px;
      end
    end else begin
      cnt = 0;
      for (int i = 0; i < Samples; i++)
        if (near(px, samples_mem[pix * 32 + i])) cnt++;
      if (cnt >= int'(m_minm)) begin
        if (draw_hits(w.roll_upd)) begin
          if (w.own < Samples) samples_mem[pix * 32 + int'(w.own)] = px;
          estimate_mem[pix] = px;
        end
        if (draw_hits(w.roll_spr)) begin
          nr = int'(w.row);
          nc = int'(w.col);
          if (w.rstep == 0 && w.row > 0) nr = int'(w.row) - 1;
          if (w.rstep == 2 && int'(w.row) + 1 < ImgHeight) nr = int'(w.row) + 1;
          if (w.cstep == 0 && w.col > 0) nc = int'(w.col) - 1;
          if (w.cstep == 2 && int'(w.col) + 1 < ImgWidth) nc = int'(w.col) + 1;
          if (w.spr_slot < Samples)
            samples_mem[(nr * ImgWidth + nc) * 32 + int'(w.spr_slot)] = px;
        end
      end else begin
        v.fg = 1'b1;
      end
    end
    e = estimate_mem[pix];
    v.e0 = e[7:0];
    v.e1 = e[15:8];
    v.e2 = e[23:16];
    return v;
  endfunction

  function automatic logic [7:0] jitter(logic [7:0] b, int amt);
    int x;
    x = int'(b) + int'($urandom_range(0, 2 * amt)) - amt;
    return x < 0 ? 8'd0 : (x > 255 ? 8'd255 : 8'(x));
  endfunction

  function automatic pixel_word_t pool_word(int k, logic f, int amt);
    pixel_word_t w;
    w.func = f;
    w.row = 8'(pool_row[k]);
    w.col = 9'(pool_col[k]);
    w.c0 = jitter(pool_color[k][7:0], amt);
    w.c1 = jitter(pool_color[k][15:8], amt);
    w.c2 = jitter(pool_color[k][23:16], amt);
    w.own = 5'($urandom_range(0, 31));
    w.roll_upd = 8'($urandom_range(0, 255));
    w.roll_spr = 8'($urandom_range(0, 255));
    w.spr_slot = 5'($urandom_range(0, 31));
    w.rstep = 2'($urandom_range(0, 3));
    w.cstep = 2'($urandom_range(0, 3));
    return w;
  endfunction

  task automatic add_random(int n);
    pixel_word_t w;
    int r;
    for (int i = 0; i < n; i++) begin
      r = int'($urandom_range(0, 99));
      w = pool_word(int'($urandom_range(0, PoolN - 1)), FUNC_DETECT, r < 60 ? 6 : 30);
      if (r >= 75 && r < 85) begin
        w.func = FUNC_LOAD;
      end else if (r >= 85 && r < 93) begin
        w.c0 = 8'($urandom_range(0, 255));
        w.c1 = 8'($urandom_range(0, 255));
        w.c2 = 8'($urandom_range(0, 255));
      end else if (r >= 93) begin
        // outside the frame, never touches memory
        w.func = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 1) != 0) w.row = 8'($urandom_range(ImgHeight, 255));
        else w.col = 9'($urandom_range(ImgWidth, 511));
      end
      pending_words = {pending_words, w};
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [8:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    do @(negedge clk);
    while (pending_words.size() != 0 || expected_verdicts.size() != 0 || in_valid);
    repeat (Drain) @(posedge clk);
  endtask

  task automatic set_regs(logic rgb, logic [8:0] md, logic [4:0] mm, logic [3:0] sh);
    write_reg(REG_RGB_MODE, {8'd0, rgb});
    write_reg(REG_MAX_DIST, md);
    write_reg(REG_MIN_MATCH, {4'd0, mm});
    write_reg(REG_UPD_SHIFT, {5'd0, sh});
  endtask

  // stimulus and phases
  initial begin
    pixel_word_t w;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = REG_RGB_MODE;
    cfg_data = '0;
    for (int k = 0; k < PoolN; k++) begin
      if (k < 4) begin
        pool_row[k] = (k < 2) ? 0 : ImgHeight - 1;
        pool_col[k] = (k % 2 == 0) ? 0 : ImgWidth - 1;
      end else begin
        pool_row[k] = int'($urandom_range(0, ImgHeight - 1));
        pool_col[k] = int'($urandom_range(0, ImgWidth - 1));
      end
      pool_color[k] = 24'($urandom);
    end
    pool_row[4] = 200;
    pool_col[4] = 300;
    pool_color[0] = 24'hffffff;
    pool_color[1] = 24'h000000;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // model set-up: slot 0 first so the estimate exists before any read
    for (int k = 0; k < PoolN; k++)
      for (int s = 0; s < Samples; s++) begin
        w = pool_word(k, FUNC_LOAD, 4);
        w.own = 5'(s);
        pending_words = {pending_words, w};
      end
    // directed corners of the space
    for (int k = 0; k < 4; k++) begin
      w = pool_word(k, FUNC_DETECT, 0);
      w.roll_upd = 8'd0;
      w.roll_spr = 8'd0;
      w.rstep = (k < 2) ? 2'd0 : 2'd2;
      w.cstep = (k % 2 == 0) ? 2'd0 : 2'd2;
      pending_words = {pending_words, w};
    end
    w = pool_word(5, FUNC_DETECT, 0);
    w.own = 5'd31; w.spr_slot = 5'd31; w.roll_upd = 8'd0; w.roll_spr = 8'd0;
    pending_words = {pending_words, w};
    w.rstep = 2'd3; w.cstep = 2'd3; w.spr_slot = 5'd19; w.own = 5'd19;
    pending_words = {pending_words, w};
    w = pool_word(6, FUNC_LOAD, 0);
    w.own = 5'd31;
    pending_words = {pending_words, w};
    w = pool_word(7, FUNC_DETECT, 0);
    w.c0 = ~pool_color[7][7:0]; w.c1 = ~pool_color[7][15:8]; w.c2 = ~pool_color[7][23:16];
    w.roll_upd = 8'hff; w.roll_spr = 8'hff;
    pending_words = {pending_words, w};
    w.row = 8'd255; w.col = 9'd511;
    pending_words = {pending_words, w};
    w.row = 8'(ImgHeight); w.col = 9'd0; w.func = FUNC_LOAD;
    pending_words = {pending_words, w};
    w.row = 8'd0; w.col = 9'(ImgWidth);
    pending_words = {pending_words, w};
    add_random(50);
    settle();

    set_regs(1'b1, 9'd20, 5'd2, 4'd0);
    add_random(170);
    settle();
    set_regs(1'b0, 9'd10, 5'd3, 4'd2);
    add_random(170);
    settle();
    set_regs(1'b1, 9'd0, 5'd1, 4'd15);
    add_random(150);
    settle();
    set_regs(1'b1, 9'd442, 5'd0, 4'd8);
    add_random(150);
    settle();
    set_regs(1'b0, 9'd442, 5'd31, 4'd1);
    add_random(150);
    settle();
    set_regs(1'b1, 9'd30, 5'd2, 4'd3);
    hold_req = 1'b1;
    add_random(180);
    settle();
    quiet = 1'b1;
    set_regs(1'b1, 9'd25, 5'd20, 4'd1);
    add_random(60);
    settle();
    set_regs(1'b1, 9'd25, 5'd2, 4'd1);
    add_random(120);
    settle();

    $display("covered %0d pixel words and %0d results (%0d foreground) over 9 settings",
             words_sent, verdicts_seen, fg_seen);
    $display("gray and rgb, border neighbours, out of frame and out of range slots");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      {func, pix_row, pix_col, chan0, chan1, chan2} <= '0;
      {own_slot, roll_update, roll_spread, spread_slot, row_step, col_step} <= '0;
    end else if (!in_valid || in_ready) begin
      if (gap_cnt > 0) begin
        gap_cnt <= gap_cnt - 1;
        in_valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        pixel_word_t w;
        w = pending_words.pop_front();
        in_valid <= 1'b1;
        func <= w.func;
        pix_row <= w.row;
        pix_col <= w.col;
        chan0 <= w.c0;
        chan1 <= w.c1;
        chan2 <= w.c2;
        own_slot <= w.own;
        roll_update <= w.roll_upd;
        roll_spread <= w.roll_spr;
        spread_slot <= w.spr_slot;
        row_step <= w.rstep;
        col_step <= w.cstep;
        if (!quiet && $urandom_range(0, 9) == 0) gap_cnt <= int'($urandom_range(1, 16));
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off so the input queue backs up
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt <= HoldCycles;
      out_ready <= 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 11) == 0) begin
      stall_cnt <= int'($urandom_range(0, 15));
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // register shadow and prediction on each accepted word
  always @(posedge clk) begin
    if (rst) begin
      m_rgb <= 1'b1;
      m_maxd <= 9'd20;
      m_minm <= 5'd2;
      m_shift <= 4'd4;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RGB_MODE: m_rgb <= cfg_data[0];
          REG_MAX_DIST: m_maxd <= cfg_data;
          REG_MIN_MATCH: m_minm <= cfg_data[4:0];
          REG_UPD_SHIFT: m_shift <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        pixel_word_t w;
        w = '{func, pix_row, pix_col, chan0, chan1, chan2, own_slot,
              roll_update, roll_spread, spread_slot, row_step, col_step};
        expected_verdicts = {expected_verdicts, classify_pixel(w)};
        words_sent++;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      verdicts_seen++;
      if (foreground) fg_seen++;
      if (expected_verdicts.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        verdict_t v;
        v = expected_verdicts.pop_front();
        if (foreground !== v.fg) begin
          $error("foreground: expected %0d, got %0d", v.fg, foreground);
          errors++;
        end
        if (est_bg0 !== v.e0) begin
          $error("est_bg0: expected %0d, got %0d", v.e0, est_bg0);
          errors++;
        end
        if (est_bg1 !== v.e1) begin
          $error("est_bg1: expected %0d, got %0d", v.e1, est_bg1);
          errors++;
        end
        if (est_bg2 !== v.e2) begin
          $error("est_bg2: expected %0d, got %0d", v.e2, est_bg2);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout, %0d results still expected", expected_verdicts.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule
